// ----- rtl/sls_pkg.sv -----
package sls_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STROBE_INTERVAL = 3'd0,
    CFG_DOT_TIME        = 3'd1,
    CFG_DASH_TIME       = 3'd2,
    CFG_GAP_TIME        = 3'd3,
    CFG_REPEAT_GAP_TIME = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_KEY   = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [7:0] KEY_W_LC = 8'h77;
  localparam logic [7:0] KEY_W_UC = 8'h57;
  localparam logic [7:0] KEY_S_LC = 8'h73;
  localparam logic [7:0] KEY_S_UC = 8'h53;
  localparam logic [7:0] KEY_F_LC = 8'h66;
  localparam logic [7:0] KEY_F_UC = 8'h46;
  localparam logic [7:0] KEY_O_LC = 8'h6f;
  localparam logic [7:0] KEY_O_UC = 8'h4f;

  localparam logic [1:0] SHADE_BLACK = 2'd0;
  localparam logic [1:0] SHADE_DIM   = 2'd1;
  localparam logic [1:0] SHADE_MID   = 2'd2;
  localparam logic [1:0] SHADE_WHITE = 2'd3;

  localparam logic [1:0] LEVEL_MIN = 2'd1;
  localparam logic [1:0] LEVEL_MAX = 2'd3;

  localparam int           SOS_STEPS = 12;
  localparam logic [3:0]   SOS_LAST  = 4'(SOS_STEPS - 1);

  typedef enum logic [2:0] {
    SYM_GAP        = 3'd0,
    SYM_DOT        = 3'd1,
    SYM_DASH       = 3'd3,
    SYM_REPEAT_GAP = 3'd5
  } sos_sym_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  key_code;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       fill_valid;
    logic [1:0] fill_shade;
    logic       lamp_running;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] strobe_interval;
    logic [CFG_DATA_W-1:0] dot_time;
    logic [CFG_DATA_W-1:0] dash_time;
    logic [CFG_DATA_W-1:0] gap_time;
    logic [CFG_DATA_W-1:0] repeat_gap_time;
  } cfg_regs_t;

  typedef struct packed {
    logic        lamp_active;
    logic [1:0]  level;
    logic        strobe_en;
    logic        sos_en;
    logic [31:0] last_change;
    logic [3:0]  step;
    logic        strobe_phase;
  } lamp_state_t;

  function automatic sos_sym_t sos_symbol(input logic [3:0] idx);
    sos_sym_t sym;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10: sym = SYM_DOT;
      4'd4, 4'd5, 4'd6:                    sym = SYM_DASH;
      4'd11:                               sym = SYM_REPEAT_GAP;
      default:                             sym = SYM_GAP;
    endcase
    return sym;
  endfunction

endpackage

// ----- rtl/sls_cfg_regs.sv -----
module sls_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sls_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sls_pkg::cfg_regs_t            cfg_o
);
  import sls_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_STROBE_INTERVAL: cfg_nxt.strobe_interval = cfg_wdata;
        CFG_DOT_TIME:        cfg_nxt.dot_time        = cfg_wdata;
        CFG_DASH_TIME:       cfg_nxt.dash_time       = cfg_wdata;
        CFG_GAP_TIME:        cfg_nxt.gap_time        = cfg_wdata;
        CFG_REPEAT_GAP_TIME: cfg_nxt.repeat_gap_time = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strobe_interval <= 16'd60;
      cfg_r.dot_time        <= 16'd200;
      cfg_r.dash_time       <= 16'd500;
      cfg_r.gap_time        <= 16'd200;
      cfg_r.repeat_gap_time <= 16'd1400;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- rtl/sls_core.sv -----
module sls_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  sls_pkg::in_item_t     item,
  input  sls_pkg::cfg_regs_t    cfg,
  output sls_pkg::out_item_t    result,
  output sls_pkg::lamp_state_t  state_o
);
  import sls_pkg::*;

  lamp_state_t state_r;
  lamp_state_t state_nxt;

  function automatic logic [1:0] paint_shade(input logic sos, input logic [1:0] level);
    logic [1:0] shade;
    if (sos) begin
      shade = SHADE_BLACK;
    end else if (level == LEVEL_MAX) begin
      shade = SHADE_WHITE;
    end else if (level == 2'd2) begin
      shade = SHADE_MID;
    end else begin
      shade = SHADE_DIM;
    end
    return shade;
  endfunction

  function automatic logic [15:0] step_interval(input sos_sym_t sym, input cfg_regs_t c);
    logic [15:0] ivl;
    case (sym)
      SYM_DOT:        ivl = c.dot_time;
      SYM_DASH:       ivl = c.dash_time;
      SYM_REPEAT_GAP: ivl = c.repeat_gap_time;
      default:        ivl = c.gap_time;
    endcase
    return ivl;
  endfunction

  logic [31:0] elapsed;
  logic [3:0]  idx;
  sos_sym_t    sym;
  logic        valid;
  logic [1:0]  shade;

  assign elapsed = item.now_ms - state_r.last_change;
  assign idx     = (state_r.step <= SOS_LAST) ? state_r.step : 4'd0;
  assign sym     = sos_symbol(idx);

  always_comb begin
    state_nxt = state_r;
    valid     = 1'b0;
    shade     = SHADE_BLACK;
    unique case (item.opcode)
      OP_START: begin
        state_nxt.lamp_active = 1'b1;
        state_nxt.level       = LEVEL_MAX;
        state_nxt.strobe_en   = 1'b0;
        state_nxt.sos_en      = 1'b0;
        valid                 = 1'b1;
      end
      OP_STOP: begin
        state_nxt.lamp_active = 1'b0;
      end
      OP_KEY: begin
        case (item.key_code) inside
          KEY_W_LC, KEY_W_UC: begin
            if (state_r.level < LEVEL_MAX) state_nxt.level = state_r.level + 2'd1;
            valid = 1'b1;
          end
          KEY_S_LC, KEY_S_UC: begin
            if (state_r.level > LEVEL_MIN) state_nxt.level = state_r.level - 2'd1;
            valid = 1'b1;
          end
          KEY_F_LC, KEY_F_UC: begin
            state_nxt.strobe_en = !state_r.strobe_en;
            state_nxt.sos_en    = 1'b0;
            valid               = 1'b1;
          end
          KEY_O_LC, KEY_O_UC: begin
            state_nxt.sos_en    = !state_r.sos_en;
            state_nxt.strobe_en = 1'b0;
            state_nxt.step      = 4'd0;
            valid               = 1'b1;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (state_r.lamp_active) begin
          if (state_r.strobe_en) begin
            if (elapsed > {16'd0, cfg.strobe_interval}) begin
              state_nxt.last_change  = item.now_ms;
              state_nxt.strobe_phase = !state_r.strobe_phase;
              valid                  = 1'b1;
              shade = state_nxt.strobe_phase ? SHADE_WHITE : SHADE_BLACK;
            end
          end else if (state_r.sos_en) begin
            if (elapsed > {16'd0, step_interval(sym, cfg)}) begin
              state_nxt.last_change = item.now_ms;
              valid                 = 1'b1;
              shade = (sym == SYM_DOT || sym == SYM_DASH) ? SHADE_WHITE : SHADE_BLACK;
              state_nxt.step = (idx == SOS_LAST) ? 4'd0 : idx + 4'd1;
            end
          end
        end
      end
      default: ;
    endcase
    // start and keys repaint from the updated state
    if (valid && item.opcode != OP_TICK) begin
      shade = paint_shade(state_nxt.sos_en, state_nxt.level);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.lamp_active  <= 1'b0;
      state_r.level        <= LEVEL_MAX;
      state_r.strobe_en    <= 1'b0;
      state_r.sos_en       <= 1'b0;
      state_r.last_change  <= 32'd0;
      state_r.step         <= 4'd0;
      state_r.strobe_phase <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  assign result.fill_valid   = valid;
  assign result.fill_shade   = shade;
  assign result.lamp_running = state_nxt.lamp_active;
  assign state_o             = state_r;

endmodule

// ----- rtl/sos_strobe_lamp_sequencer_unit.sv -----
// SOS / strobe lamp sequencer. Every accepted item (tick, key, start, stop)
// yields exactly one result item. An item is held in an input register,
// processed in a single pass against the lamp state and written to the result
// register, so one item is taken per cycle; the item passes the input register
// and then the result register before its result is valid. Throughput is one
// item per cycle, limited only by stall on the result side. Configuration
// writes are applied at once and must only be issued while the block is idle.
module sos_strobe_lamp_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  sls_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output sls_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [sls_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sls_pkg::*;

  logic        s0_valid_r;
  in_item_t    s0_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        s0_adv;
  logic        in_xfer;
  cfg_regs_t   cfg;
  out_item_t   result;
  lamp_state_t state;

  assign s0_adv   = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s0_valid_r && !s0_adv;
  assign in_xfer  = in_valid && !in_stall;

  sls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  sls_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s0_adv),
    .item    (s0_item_r),
    .cfg     (cfg),
    .result  (result),
    .state_o (state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s0_valid_r <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_no_repaint_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.fill_valid |-> out_item_r.fill_shade == SHADE_BLACK)
    else $error("result without repaint carries a shade");

  a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state.strobe_en && state.sos_en))
    else $error("strobe and SOS both enabled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    state.level != 2'd0)
    else $error("brightness level out of range");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state.step <= SOS_LAST)
    else $error("SOS step out of range");

endmodule
